[sv/gil_pkg.sv]
// Shared widths, register indexes, wrap mode codes and types of the grid index linearizer.
package gil_pkg;

    localparam int IDX_W       = 32;  // one signed index component
    localparam int EXT_W       = 16;  // one dimension extent
    localparam int COMP_W      = IDX_W + 1;  // mapped component, signed
    localparam int OFFSET_W    = 48;  // linear offset port
    localparam int LIMB_W      = 32;  // multiplier slice of the accumulator
    localparam int NUM_EXTENTS = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = EXT_W;
    localparam int DIM_CNT_W   = 3;
    localparam int MODE_W      = 2;

    // remainder unit: radix-2 steps per pipeline stage
    localparam int RDX_BITS    = 4;
    localparam int WRAP_STAGES = IDX_W / RDX_BITS;

    localparam int MAX_DIMS_DEF  = 6;
    localparam int ADDR_BITS_DEF = 48;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_MODE = 3'd1;
    localparam int                     REG_EXTENT_0  = 2;

    // wrap modes
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FFT      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd2;

    typedef logic        [MODE_W-1:0] mode_t;
    typedef logic        [EXT_W-1:0]  ext_t;
    typedef logic signed [IDX_W-1:0]  idx_t;
    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        mode_t mode;
        ext_t  extent;
    } lane_cfg_t;

endpackage

[sv/grid_index_linearizer_core.sv]
// Top level of the grid index linearizer: config registers, wrap lanes, row-major chain.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------------------
//  config    | cfg_write                    | cfg_index, cfg_data
//  item in   | item_valid / item_stall      | index_0 .. index_5
//  result    | result_valid / result_stall  | linear_offset, overflow
//
// One item per cycle while the pipeline advances. Its stages are the eight
// remainder stages of four bits each plus the mode select in every wrap lane,
// a multiply and an add stage per dimension, and the output register. The whole
// pipeline advances together; it holds only while a result is waiting and
// result_stall is high, and item_stall says just that.
// Reset clears the valid bits and sets the registers to one dimension, identity
// mode and all extents one.
module grid_index_linearizer_core #(
    parameter int MAX_DIMS  = gil_pkg::MAX_DIMS_DEF,
    parameter int ADDR_BITS = gil_pkg::ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [gil_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gil_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  gil_pkg::idx_t                      index_0,
    input  gil_pkg::idx_t                      index_1,
    input  gil_pkg::idx_t                      index_2,
    input  gil_pkg::idx_t                      index_3,
    input  gil_pkg::idx_t                      index_4,
    input  gil_pkg::idx_t                      index_5,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [gil_pkg::OFFSET_W-1:0]       linear_offset,
    output logic                               overflow
);
    import gil_pkg::*;

    // exact offset bound: |acc| < 2^(COMP_W + EXT_W*(dims-1)), plus sign
    localparam int ACC_BASE = COMP_W + 1 + EXT_W * (MAX_DIMS - 1);
    localparam int ACC_A    = (ACC_BASE > ADDR_BITS + 1) ? ACC_BASE : ADDR_BITS + 1;
    localparam int ACC_W    = (ACC_A > OFFSET_W + 1) ? ACC_A : OFFSET_W + 1;
    localparam int WRAP_LAT = WRAP_STAGES + 1;

    localparam logic [OFFSET_W-1:0] OFF_MASK =
        (ADDR_BITS >= OFFSET_W) ? {OFFSET_W{1'b1}}
                                : ((OFFSET_W'(1) << ADDR_BITS) - OFFSET_W'(1));
    localparam logic [ACC_W-1:0] HI_MASK = ~((ACC_W'(1) << ADDR_BITS) - ACC_W'(1));

    // configuration
    logic [DIM_CNT_W-1:0] dim_count_reg;
    mode_t                wrap_mode_reg;
    ext_t                 extent_reg [NUM_EXTENTS];
    logic [DIM_CNT_W-1:0] dim_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= DIM_CNT_W'(1);
            wrap_mode_reg <= MODE_IDENTITY;
            for (int k = 0; k < NUM_EXTENTS; k++)
            begin
                extent_reg[k] <= EXT_W'(1);
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_DIM_COUNT)
            begin
                dim_count_reg <= cfg_data[DIM_CNT_W-1:0];
            end
            if (cfg_index == REG_WRAP_MODE)
            begin
                wrap_mode_reg <= cfg_data[MODE_W-1:0];
            end
            for (int k = 0; k < NUM_EXTENTS; k++)
            begin
                if (cfg_index == CFG_INDEX_W'(REG_EXTENT_0 + k))
                begin
                    extent_reg[k] <= cfg_data[EXT_W-1:0];
                end
            end
        end
    end

    // zero counts as one dimension, anything above the build limit saturates
    always_comb
    begin
        if (dim_count_reg == '0)
        begin
            dim_eff = DIM_CNT_W'(1);
        end
        else if (dim_count_reg > DIM_CNT_W'(MAX_DIMS))
        begin
            dim_eff = DIM_CNT_W'(MAX_DIMS);
        end
        else
        begin
            dim_eff = dim_count_reg;
        end
    end

    // global advance: everything moves unless a result is held back
    logic adv;
    logic result_valid_reg;

    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;

    // wrap lanes
    idx_t      index_arr [NUM_EXTENTS];
    comp_t     lane_comp [MAX_DIMS];
    lane_cfg_t lane_cfg  [MAX_DIMS];
    logic      wrap_valid_reg [WRAP_LAT];

    assign index_arr[0] = index_0;
    assign index_arr[1] = index_1;
    assign index_arr[2] = index_2;
    assign index_arr[3] = index_3;
    assign index_arr[4] = index_4;
    assign index_arr[5] = index_5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WRAP_LAT; k++)
            begin
                wrap_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            wrap_valid_reg[0] <= item_valid;
            for (int k = 1; k < WRAP_LAT; k++)
            begin
                wrap_valid_reg[k] <= wrap_valid_reg[k-1];
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_DIMS; i++)
        begin : g_lane
            assign lane_cfg[i] = '{mode: wrap_mode_reg, extent: extent_reg[i]};

            gil_wrap_lane u_lane (
                .clk  (clk),
                .en   (adv),
                .cfg  (lane_cfg[i]),
                .idx  (index_arr[i]),
                .comp (lane_comp[i])
            );
        end
    endgenerate

    // inactive dimensions become extent one, component zero
    logic [MAX_DIMS-1:0]               active;
    ext_t                              stage_extent [MAX_DIMS];
    logic [ACC_W-1:0]                  acc_chain    [MAX_DIMS+1];
    logic [MAX_DIMS-1:0][COMP_W-1:0]   comps_chain  [MAX_DIMS+1];
    logic                              valid_chain  [MAX_DIMS+1];

    always_comb
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            active[k]          = DIM_CNT_W'(k) < dim_eff;
            stage_extent[k]    = active[k] ? extent_reg[k] : EXT_W'(1);
            comps_chain[0][k]  = active[k] ? lane_comp[k] : '0;
        end
    end

    assign acc_chain[0]   = '0;
    assign valid_chain[0] = wrap_valid_reg[WRAP_LAT-1];

    generate
        for (i = 0; i < MAX_DIMS; i++)
        begin : g_horner
            gil_horner_stage #(
                .MAX_DIMS (MAX_DIMS),
                .ACC_W    (ACC_W),
                .DIM      (i)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .valid_in  (valid_chain[i]),
                .acc_in    (acc_chain[i]),
                .comps_in  (comps_chain[i]),
                .extent    (stage_extent[i]),
                .valid_out (valid_chain[i+1]),
                .acc_out   (acc_chain[i+1]),
                .comps_out (comps_chain[i+1])
            );
        end
    endgenerate

    // output register: address bits and the out-of-range flag (negative included)
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic                overflow_reg;
    logic                overflow_next;

    assign offset_next   = acc_chain[MAX_DIMS][OFFSET_W-1:0] & OFF_MASK;
    assign overflow_next = |(acc_chain[MAX_DIMS] & HI_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= valid_chain[MAX_DIMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            offset_reg   <= offset_next;
            overflow_reg <= overflow_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign linear_offset = offset_reg;
    assign overflow      = overflow_reg;

endmodule

[sv/gil_wrap_lane.sv]
// Wrap mapping of one index component: pipelined remainder plus mode select.
module gil_wrap_lane (
    input  logic               clk,
    input  logic               en,
    input  gil_pkg::lane_cfg_t cfg,
    input  gil_pkg::idx_t      idx,
    output gil_pkg::comp_t     comp
);
    import gil_pkg::*;

    localparam int LAST = WRAP_STAGES - 1;

    idx_t             idx_reg [WRAP_STAGES];
    logic [IDX_W-1:0] mag_reg [WRAP_STAGES];
    ext_t             rem_reg [WRAP_STAGES];
    comp_t            comp_reg;
    comp_t            comp_next;

    idx_t             idx_in   [WRAP_STAGES];
    logic [IDX_W-1:0] mag_in   [WRAP_STAGES];
    ext_t             rem_in   [WRAP_STAGES];
    logic [IDX_W-1:0] mag_next [WRAP_STAGES];
    ext_t             rem_next [WRAP_STAGES];

    // one restoring remainder step
    function automatic ext_t rem_step(input ext_t rem, input logic din, input ext_t e);
        logic [EXT_W:0] t;
        t = {rem, din};
        if (t >= {1'b0, e})
        begin
            t = t - {1'b0, e};
        end
        return t[EXT_W-1:0];
    endfunction

    genvar s;
    generate
        for (s = 0; s < WRAP_STAGES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                always_comb
                begin
                    idx_in[s] = idx;
                    mag_in[s] = idx[IDX_W-1] ? (~idx + 1'b1) : idx;
                    rem_in[s] = '0;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    idx_in[s] = idx_reg[s-1];
                    mag_in[s] = mag_reg[s-1];
                    rem_in[s] = rem_reg[s-1];
                end
            end

            always_comb
            begin
                rem_next[s] = rem_in[s];
                mag_next[s] = mag_in[s];
                for (int j = 0; j < RDX_BITS; j++)
                begin
                    rem_next[s] = rem_step(rem_next[s], mag_next[s][IDX_W-1], cfg.extent);
                    mag_next[s] = mag_next[s] << 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    idx_reg[s] <= idx_in[s];
                    mag_reg[s] <= mag_next[s];
                    rem_reg[s] <= rem_next[s];
                end
            end
        end
    endgenerate

    always_comb
    begin
        case (cfg.mode)
            MODE_FFT:
            begin
                if (idx_reg[LAST][IDX_W-1])
                begin
                    comp_next = COMP_W'(idx_reg[LAST]) + COMP_W'($signed({1'b0, cfg.extent}));
                end
                else
                begin
                    comp_next = COMP_W'(idx_reg[LAST]);
                end
            end
            MODE_PERIODIC:
            begin
                if (cfg.extent == '0)
                begin
                    comp_next = '0;
                end
                else if (idx_reg[LAST][IDX_W-1] && (rem_reg[LAST] != '0))
                begin
                    comp_next = COMP_W'({1'b0, cfg.extent - rem_reg[LAST]});
                end
                else
                begin
                    comp_next = COMP_W'({1'b0, rem_reg[LAST]});
                end
            end
            default:
            begin
                comp_next = COMP_W'(idx_reg[LAST]);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            comp_reg <= comp_next;
        end
    end

    assign comp = comp_reg;

endmodule

[sv/gil_horner_stage.sv]
// One row-major step acc * extent + component, split into multiply and add stages.
module gil_horner_stage #(
    parameter int MAX_DIMS = gil_pkg::MAX_DIMS_DEF,
    parameter int ACC_W    = 114,
    parameter int DIM      = 0
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        valid_in,
    input  logic [ACC_W-1:0]                            acc_in,
    input  logic [MAX_DIMS-1:0][gil_pkg::COMP_W-1:0]    comps_in,
    input  gil_pkg::ext_t                               extent,
    output logic                                        valid_out,
    output logic [ACC_W-1:0]                            acc_out,
    output logic [MAX_DIMS-1:0][gil_pkg::COMP_W-1:0]    comps_out
);
    import gil_pkg::*;

    localparam int LIMBS  = (ACC_W + LIMB_W - 1) / LIMB_W;
    localparam int PAD_W  = LIMBS * LIMB_W;
    localparam int PROD_W = LIMB_W + EXT_W;

    logic [PAD_W-1:0]        acc_pad;
    logic [PROD_W-1:0]       prod [LIMBS];
    logic [PAD_W+EXT_W-1:0]  even_v;
    logic [PAD_W+EXT_W-1:0]  odd_v;

    logic                          mul_valid_reg;
    logic [ACC_W-1:0]              even_reg;
    logic [ACC_W-1:0]              odd_reg;
    logic [MAX_DIMS-1:0][COMP_W-1:0] mul_comps_reg;

    logic                          add_valid_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic [ACC_W-1:0]              acc_next;
    logic [MAX_DIMS-1:0][COMP_W-1:0] add_comps_reg;

    // limb products; even and odd limbs never overlap within their own group
    always_comb
    begin
        acc_pad = PAD_W'(acc_in);
        even_v  = '0;
        odd_v   = '0;
        for (int k = 0; k < LIMBS; k++)
        begin
            prod[k] = PROD_W'(acc_pad[k*LIMB_W +: LIMB_W]) * PROD_W'(extent);
        end
        for (int k = 0; k < LIMBS; k += 2)
        begin
            even_v[k*LIMB_W +: PROD_W] = prod[k];
        end
        for (int k = 1; k < LIMBS; k += 2)
        begin
            odd_v[k*LIMB_W +: PROD_W] = prod[k];
        end
    end

    assign acc_next = even_reg + odd_reg + ACC_W'($signed(mul_comps_reg[DIM]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= valid_in;
            add_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            even_reg      <= even_v[ACC_W-1:0];
            odd_reg       <= odd_v[ACC_W-1:0];
            mul_comps_reg <= comps_in;
            acc_reg       <= acc_next;
            add_comps_reg <= mul_comps_reg;
        end
    end

    assign valid_out = add_valid_reg;
    assign acc_out   = acc_reg;
    assign comps_out = add_comps_reg;

endmodule
